// File: hdl/assert_macros.svh
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while the reset is asserted.
`define VTD_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is checked in every cycle, reset included.
`define VTD_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/vtd_pkg.sv
// Package with the word types and constants of the vertex transform block.
package vtd_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_XFORM = 1'b1;

	typedef struct packed {
		logic               opcode;
		logic [3:0]         entry_index;
		logic signed [31:0] entry_value;
		logic signed [31:0] in_x;
		logic signed [31:0] in_y;
		logic signed [31:0] in_z;
		logic signed [31:0] in_w;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic signed [31:0] out_w;
		logic               overflow;
	} out_word_t;

	// A command after classification by the front end.
	typedef struct packed {
		logic               xform;
		logic [3:0]         entry_index;
		logic signed [31:0] entry_value;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] vz;
		logic signed [31:0] vw;
	} cmd_t;

	// Head of the command queue as seen by the back end.
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_head_t;

endpackage

// File: hdl/vtd_front.sv
// Front end: accepts input words, classifies them and queues the commands.
module vtd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  vtd_pkg::in_word_t  in_word,
	output vtd_pkg::q_head_t   head,
	input  logic               take
);
	localparam int DEPTH = vtd_pkg::QUEUE_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	vtd_pkg::cmd_t  mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push, do_take;
	vtd_pkg::cmd_t  cmd_new;

	always_comb begin
		cmd_new.xform       = (in_word.opcode == vtd_pkg::OP_XFORM);
		cmd_new.entry_index = in_word.entry_index;
		cmd_new.entry_value = in_word.entry_value;
		cmd_new.vx          = in_word.in_x;
		cmd_new.vy          = in_word.in_y;
		cmd_new.vz          = in_word.in_z;
		cmd_new.vw          = in_word.in_w;
	end

	assign full       = (count_q == CW'(DEPTH));
	assign do_push    = push && !full;
	assign head.valid = (count_q != '0);
	assign head.cmd   = mem_q[rd_ptr_q];
	assign do_take    = take && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= cmd_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_take) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CW'(do_push) - CW'(do_take);
		end
	end
endmodule

// File: hdl/vtd_back.sv
// Back end: matrix store, shared multiplier, serial divider and result register.
module vtd_back #(
	parameter int FRAC_BITS = vtd_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  vtd_pkg::q_head_t   head,
	output logic               take,
	input  logic               den,
	output logic               empty,
	input  logic               pop,
	output vtd_pkg::out_word_t out_word
);
	localparam int ACC_W = 66 - FRAC_BITS;
	localparam int QW    = 32 + FRAC_BITS;
	localparam int BW    = $clog2(QW);
	localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
	localparam logic signed [ACC_W-1:0] MAXV = ACC_W'(32'sh7fffffff);
	localparam logic signed [ACC_W-1:0] MINV = ACC_W'(signed'(32'h80000000));

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MAC   = 3'd1;
	localparam logic [2:0] S_DLOAD = 3'd2;
	localparam logic [2:0] S_DITER = 3'd3;
	localparam logic [2:0] S_DFIN  = 3'd4;
	localparam logic [2:0] S_OUT   = 3'd5;

	logic [2:0]         state_q;
	logic signed [31:0] mat_q [16];
	logic signed [31:0] vec_q [4];
	logic signed [31:0] res_q [4];
	logic               ovf_q;
	logic [4:0]         cnt_q;
	logic signed [63:0] prod_s1;
	logic               prod_v_s1, prod_last_s1;
	logic [1:0]         prod_col_s1;
	logic signed [ACC_W-1:0] acc_q;
	logic [1:0]         qi_q;
	logic [BW-1:0]      bcnt_q;
	logic [QW-1:0]      nmag_q;
	logic [32:0]        rem_q;
	logic [31:0]        dmag_q;
	logic               neg_q;
	logic               ovalid_q;
	vtd_pkg::out_word_t out_q;

	logic signed [63:0]      mul_w;
	logic signed [ACC_W-1:0] sum_w;
	logic signed [31:0]      sat_w;
	logic                    sat_ovf_w;
	logic signed [31:0]      dsel_w, v_w;
	logic [31:0]             vmag_w;
	logic [32:0]             trial_w;
	logic                    qbit_w;
	logic                    q_big_neg, q_big_pos;
	logic                    out_free;

	assign out_free = !ovalid_q || pop;
	assign take     = (state_q == S_IDLE) && head.valid;
	assign empty    = !ovalid_q;
	assign out_word = out_q;

	assign mul_w = vec_q[cnt_q[1:0]] * mat_q[{cnt_q[1:0], cnt_q[3:2]}];
	assign sum_w = acc_q + ACC_W'(prod_s1 >>> FRAC_BITS);

	always_comb begin
		sat_ovf_w = 1'b0;
		sat_w     = 32'(sum_w);
		if (sum_w > MAXV) begin
			sat_w     = 32'sh7fffffff;
			sat_ovf_w = 1'b1;
		end else if (sum_w < MINV) begin
			sat_w     = signed'(32'h80000000);
			sat_ovf_w = 1'b1;
		end
	end

	assign dsel_w  = (res_q[3] == '0) ? ONE : res_q[3];
	assign v_w     = res_q[qi_q];
	assign vmag_w  = v_w[31] ? 32'(-v_w) : 32'(v_w);
	assign trial_w = {rem_q[31:0], nmag_q[QW-1]};
	assign qbit_w  = (trial_w >= {1'b0, dmag_q});
	assign q_big_neg = (|nmag_q[QW-1:32]) || (nmag_q[31] && (|nmag_q[30:0]));
	assign q_big_pos = |nmag_q[QW-1:31];

	always_ff @(posedge clk) begin
		prod_s1 <= mul_w;
		unique case (state_q)
			S_IDLE: begin
				if (head.valid && head.cmd.xform) begin
					vec_q[0] <= head.cmd.vx;
					vec_q[1] <= head.cmd.vy;
					vec_q[2] <= head.cmd.vz;
					vec_q[3] <= head.cmd.vw;
					acc_q    <= '0;
					ovf_q    <= 1'b0;
				end
			end
			S_MAC: begin
				if (prod_v_s1) begin
					if (prod_last_s1) begin
						res_q[prod_col_s1] <= sat_w;
						ovf_q <= ovf_q | sat_ovf_w;
						acc_q <= '0;
					end else begin
						acc_q <= sum_w;
					end
				end
			end
			S_DLOAD: begin
				dmag_q <= dsel_w[31] ? 32'(-dsel_w) : 32'(dsel_w);
				neg_q  <= v_w[31] ^ dsel_w[31];
				nmag_q <= {vmag_w, {FRAC_BITS{1'b0}}};
				rem_q  <= '0;
			end
			S_DITER: begin
				rem_q  <= qbit_w ? (trial_w - {1'b0, dmag_q}) : trial_w;
				nmag_q <= {nmag_q[QW-2:0], qbit_w};
			end
			S_DFIN: begin
				if (neg_q) begin
					res_q[qi_q] <= q_big_neg ? signed'(32'h80000000) : 32'(-nmag_q[31:0]);
					ovf_q <= ovf_q | q_big_neg;
				end else begin
					res_q[qi_q] <= q_big_pos ? 32'sh7fffffff : signed'(nmag_q[31:0]);
					ovf_q <= ovf_q | q_big_pos;
				end
				if (qi_q == 2'd2) begin
					res_q[3] <= (res_q[3] == '0) ? '0 : ONE;
				end
			end
			S_OUT: begin
				if (out_free) begin
					out_q.out_x    <= res_q[0];
					out_q.out_y    <= res_q[1];
					out_q.out_z    <= res_q[2];
					out_q.out_w    <= res_q[3];
					out_q.overflow <= ovf_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			prod_v_s1    <= 1'b0;
			prod_last_s1 <= 1'b0;
			prod_col_s1  <= '0;
			qi_q         <= '0;
			bcnt_q       <= '0;
			ovalid_q     <= 1'b0;
			for (int i = 0; i < 16; i++) begin
				mat_q[i] <= ((i % 5) == 0) ? ONE : '0;
			end
		end else begin
			prod_v_s1    <= (state_q == S_MAC) && !cnt_q[4];
			prod_last_s1 <= (cnt_q[1:0] == 2'b11);
			prod_col_s1  <= cnt_q[3:2];
			if ((state_q == S_OUT) && out_free) begin
				ovalid_q <= 1'b1;
			end else if (pop) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (head.valid) begin
						if (head.cmd.xform) begin
							cnt_q   <= '0;
							state_q <= S_MAC;
						end else begin
							mat_q[head.cmd.entry_index] <= head.cmd.entry_value;
						end
					end
				end
				S_MAC: begin
					if (!cnt_q[4]) begin
						cnt_q <= cnt_q + 1'b1;
					end else if (!prod_v_s1) begin
						qi_q    <= '0;
						state_q <= den ? S_DLOAD : S_OUT;
					end
				end
				S_DLOAD: begin
					bcnt_q  <= '0;
					state_q <= S_DITER;
				end
				S_DITER: begin
					bcnt_q <= bcnt_q + 1'b1;
					if (bcnt_q == BW'(QW - 1)) begin
						state_q <= S_DFIN;
					end
				end
				S_DFIN: begin
					qi_q    <= qi_q + 1'b1;
					state_q <= (qi_q == 2'd2) ? S_OUT : S_DLOAD;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

// File: hdl/vertex_transform_divide_core.sv
// A transform word passes through the matrix product and, with division on, the divider before
// its result is written to the output register; the back end waits in S_OUT while that is full.
// With division on, each of the three quotients comes from a one-bit-per-cycle divider.
// The back end takes a new vertex only after the last result is in the output register.
// The two-entry input queue holds up to two words ahead of the back end, then full is raised.
// Reset (arst_n low) empties the queue and result register, loads identity, clears division.
module vertex_transform_divide_core #(
	parameter int FRAC_BITS = vtd_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  vtd_pkg::in_word_t  in_word,
	output logic               empty,
	input  logic               pop,
	output vtd_pkg::out_word_t out_word,
	input  logic               cfg_we,
	input  logic               cfg_wdata
);
	// Perspective division enable. It is only to be written while the block is idle, a user rule
	// that the block itself does not enforce, so the back end may sample it at the end of the matrix product.
	logic den_q;

	// Queue head travels from the front end to the back end as one struct.
	vtd_pkg::q_head_t head;
	logic             take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			den_q <= 1'b0;
		end else if (cfg_we) begin
			den_q <= cfg_wdata;
		end
	end

	// The front end decodes the opcode and buffers commands, so the source can run up to
	// two words ahead of the back end while a long division is in progress.
	vtd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.in_word (in_word),
		.head    (head),
		.take    (take)
	);

	// The back end applies loads in order with transforms, so a load never changes
	// a vertex that was queued ahead of it.
	vtd_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.take     (take),
		.den      (den_q),
		.empty    (empty),
		.pop      (pop),
		.out_word (out_word)
	);
endmodule

// File: hdl/vtd_checker.sv
// Port-level checker for the vertex transform block, with its bind statement.
`include "assert_macros.svh"

module vtd_checker #(
	parameter int FRAC_BITS = vtd_pkg::FRAC_BITS_DEF
) (
	input logic               clk,
	input logic               arst_n,
	input logic               empty,
	input logic               pop,
	input vtd_pkg::out_word_t out_word,
	input logic               cfg_we,
	input logic               cfg_wdata
);
	localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

	logic den_q;
	logic waiting;
	logic div_wait;
	logic w_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			den_q <= 1'b0;
		end else if (cfg_we) begin
			den_q <= cfg_wdata;
		end
	end

	assign waiting  = !empty && !pop;
	assign div_wait = !empty && den_q;
	assign w_ok     = (out_word.out_w == ONE) || (out_word.out_w == '0);

	`VTD_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |=> empty, "not empty after reset")
	`VTD_ASSERT(a_word_hold, clk, arst_n, waiting |=> !empty && $stable(out_word), "word changed")
	`VTD_ASSERT(a_div_w, clk, arst_n, div_wait |-> w_ok, "divided w is neither one nor zero")
endmodule

bind vertex_transform_divide_core vtd_checker #(.FRAC_BITS(FRAC_BITS)) u_vtd_checker (.*);
